// ===== rtl/smrm_pkg.sv =====
// Shared types and constants for the square matrix rotation match block.
// No dependencies; imported by the sequencer, the address unit and the checker.
`default_nettype none
package smrm_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int SIZE_RESET  = 16;
  localparam int SIZE_W      = 5;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 8;
  localparam int CFG_W       = 8;
  localparam int NUM_TURNS   = 4;

  // result beat bit positions
  localparam int OUT_MATCHED = 0;
  localparam int OUT_QT_LO   = 1;
  localparam int OUT_QT_HI   = 2;
  localparam int OUT_SIZE_ER = 3;

  typedef enum logic [1:0] {
    TURN_0 = 2'd0,
    TURN_1 = 2'd1,
    TURN_2 = 2'd2,
    TURN_3 = 2'd3
  } turn_t;

  localparam logic FUNC_FIRST  = 1'b0;
  localparam logic FUNC_SECOND = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/smrm_addr.sv =====
// Address unit: maps a position and a clockwise quarter-turn count to a
// first-matrix memory address (row stride MAX_DIM). Depends on smrm_pkg.
`default_nettype none
module smrm_addr #(
  parameter int MAX_DIM = smrm_pkg::MAX_DIM_DEF,
  parameter int PW      = 4,
  parameter int AW      = 8
) (
  input  logic [PW-1:0]       row,
  input  logic [PW-1:0]       col,
  input  logic [PW-1:0]       nm1,
  input  smrm_pkg::turn_t     turn,
  output logic [AW-1:0]       addr
);
  import smrm_pkg::*;

  logic [PW-1:0] src_row;
  logic [PW-1:0] src_col;

  always_comb begin
    unique case (turn)
      TURN_0: begin
        src_row = row;
        src_col = col;
      end
      TURN_1: begin
        src_row = nm1 - col;
        src_col = row;
      end
      TURN_2: begin
        src_row = nm1 - row;
        src_col = nm1 - col;
      end
      TURN_3: begin
        src_row = col;
        src_col = nm1 - row;
      end
      default: begin
        src_row = row;
        src_col = col;
      end
    endcase
  end

  assign addr = AW'(AW'(src_row) * AW'(MAX_DIM)) + AW'(src_col);

endmodule
`default_nettype wire

// ===== rtl/square_matrix_rotation_match.sv =====
// Input flow: first-matrix beats are accepted back to back while cfg_tvalid is low; after a
// second-matrix beat in_tready stays low for four single-port memory reads and the compare.
// A result is registered in S_CMP after the reads for the last second-matrix beat, later while
// an earlier result beat still waits on out_tready.
// Reset (rst_n, synchronous, active low) clears control state and sets size 16, or MAX_DIM
// if smaller; the first-matrix memory is not cleared. Depends on smrm_pkg and smrm_addr.
`default_nettype none
module square_matrix_rotation_match #(
  parameter int MAX_DIM = smrm_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [smrm_pkg::IN_W-1:0]  in_tdata,   // [31:0] element_value
  input  logic                       in_tuser,   // [0] func
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [smrm_pkg::OUT_W-1:0] out_tdata,  // [0] matched, [2:1] quarter_turns,
                                                 // [3] size_error, [7:4] zero
  input  logic                       cfg_tvalid,
  output logic                       cfg_tready,
  input  logic [smrm_pkg::CFG_W-1:0] cfg_tdata   // [4:0] matrix_size, [7:5] unused
);
  import smrm_pkg::*;

  localparam int PW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RESET_N = (SIZE_RESET > MAX_DIM) ? MAX_DIM : SIZE_RESET;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  turn_t                 turn_r, turn_nxt;
  turn_t                 cmp_turn_r, cmp_turn_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [PW-1:0]         nm1_r, nm1_nxt;
  logic [PW-1:0]         pos_row_r, pos_row_nxt;
  logic [PW-1:0]         pos_col_r, pos_col_nxt;
  logic [PW-1:0]         cur_row_r, cur_row_nxt;
  logic [PW-1:0]         cur_col_r, cur_col_nxt;
  logic [NUM_TURNS-1:0]  flags_r, flags_nxt;
  logic                  err_r, err_nxt;
  logic                  last_r, last_nxt;
  logic [IN_W-1:0]       val_r, val_nxt;
  logic [IN_W-1:0]       rdata_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic [IN_W-1:0]       mem [DEPTH];
  logic [AW-1:0]         addr;
  logic [PW-1:0]         a_row;
  logic [PW-1:0]         a_col;
  turn_t                 a_turn;
  logic                  mem_we;
  logic                  rd_en;

  logic                  in_acc;
  logic                  at_end;
  logic [SIZE_W-1:0]     cfg_size;
  int                    cfg_n;
  logic [NUM_TURNS-1:0]  flags_cmp;
  logic                  res_matched;
  logic [1:0]            res_qt;

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == S_IDLE) && !cfg_tvalid;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign at_end     = (pos_row_r == nm1_r) && (pos_col_r == nm1_r);
  assign cfg_size   = cfg_tdata[SIZE_W-1:0];

  always_comb begin
    if (cfg_size == '0) begin
      cfg_n = 1;
    end else if (int'(cfg_size) > MAX_DIM) begin
      cfg_n = MAX_DIM;
    end else begin
      cfg_n = int'(cfg_size);
    end
  end

  // compare of the word read in the previous cycle
  assign flags_cmp = (cmp_vld_r && (rdata_r != val_r)) ?
                     (flags_r & ~(NUM_TURNS'(1) << cmp_turn_r)) : flags_r;

  always_comb begin
    res_matched = !err_r && (flags_cmp != '0);
    priority if (!res_matched) begin
      res_qt = 2'd0;
    end else if (flags_cmp[TURN_0]) begin
      res_qt = TURN_0;
    end else if (flags_cmp[TURN_1]) begin
      res_qt = TURN_1;
    end else if (flags_cmp[TURN_2]) begin
      res_qt = TURN_2;
    end else begin
      res_qt = TURN_3;
    end
  end

  assign a_row  = (state_r == S_IDLE) ? pos_row_r : cur_row_r;
  assign a_col  = (state_r == S_IDLE) ? pos_col_r : cur_col_r;
  assign a_turn = (state_r == S_IDLE) ? TURN_0 : turn_r;

  smrm_addr #(
    .MAX_DIM (MAX_DIM),
    .PW      (PW),
    .AW      (AW)
  ) u_addr (
    .row  (a_row),
    .col  (a_col),
    .nm1  (nm1_r),
    .turn (a_turn),
    .addr (addr)
  );

  always_comb begin
    state_nxt     = state_r;
    turn_nxt      = turn_r;
    cmp_turn_nxt  = cmp_turn_r;
    cmp_vld_nxt   = 1'b0;
    nm1_nxt       = nm1_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    flags_nxt     = flags_cmp;
    err_nxt       = err_r;
    last_nxt      = last_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_row_nxt = pos_row_r;
          cur_col_nxt = pos_col_r;
          val_nxt     = in_tdata;
          last_nxt    = in_tlast;
          mem_we      = (in_tuser == FUNC_FIRST);
          if (in_tuser == FUNC_SECOND) begin
            state_nxt = S_READ;
            turn_nxt  = TURN_0;
          end
          if (in_tlast) begin
            if (!at_end) begin
              err_nxt = 1'b1;
            end
            pos_row_nxt = '0;
            pos_col_nxt = '0;
            if (in_tuser == FUNC_FIRST) begin
              flags_nxt = '1;
            end
          end else if (at_end) begin
            err_nxt     = 1'b1;
            pos_row_nxt = '0;
            pos_col_nxt = '0;
          end else if (pos_col_r == nm1_r) begin
            pos_col_nxt = '0;
            pos_row_nxt = pos_row_r + PW'(1);
          end else begin
            pos_col_nxt = pos_col_r + PW'(1);
          end
        end
      end
      S_READ: begin
        rd_en        = 1'b1;
        cmp_vld_nxt  = 1'b1;
        cmp_turn_nxt = turn_r;
        turn_nxt     = turn_t'(turn_r + 2'd1);
        if (turn_r == TURN_3) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OUT_MATCHED]           = res_matched;
          out_data_nxt[OUT_QT_HI:OUT_QT_LO]   = res_qt;
          out_data_nxt[OUT_SIZE_ER]           = err_r;
          err_nxt       = 1'b0;
          flags_nxt     = '1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_tvalid) begin
      nm1_nxt     = PW'(cfg_n - 1);
      pos_row_nxt = '0;
      pos_col_nxt = '0;
      flags_nxt   = '1;
      err_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= in_tdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      turn_r      <= TURN_0;
      cmp_turn_r  <= TURN_0;
      cmp_vld_r   <= 1'b0;
      nm1_r       <= PW'(RESET_N - 1);
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      flags_r     <= '1;
      err_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      turn_r      <= turn_nxt;
      cmp_turn_r  <= cmp_turn_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      nm1_r       <= nm1_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      flags_r     <= flags_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/smrm_checker.sv =====
// Port-level checker for square_matrix_rotation_match, attached by bind.
// Depends on smrm_pkg.
`default_nettype none
module smrm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [smrm_pkg::OUT_W-1:0] out_tdata
);
  import smrm_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_SIZE_ER] |->
      !out_tdata[OUT_MATCHED] && (out_tdata[OUT_QT_HI:OUT_QT_LO] == 2'd0))
    else $error("size error result carries a match");

  a_nomatch_qt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_MATCHED] |-> out_tdata[OUT_QT_HI:OUT_QT_LO] == 2'd0)
    else $error("quarter turns set without a match");

  a_second_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_SECOND) |=> !in_tready ##1 !in_tready)
    else $error("second-matrix beat did not hold off input");

endmodule

bind square_matrix_rotation_match smrm_checker u_smrm_checker (.*);
`default_nettype wire

// ===== tb/sv/square_matrix_rotation_match_tb.sv =====
// Self-checking bench for square_matrix_rotation_match: streams matrix pairs,
// tracks the four turn flags per element and checks every result beat.
// Depends on smrm_pkg and the square_matrix_rotation_match RTL.
module square_matrix_rotation_match_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smrm_pkg::*;

  localparam int DIM          = MAX_DIM_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic  matched;
    turn_t turns;
    logic  size_err;
  } verdict_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // [31:0] element_value
  logic             in_tuser   = 1'b0; // [0] func
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // [0] matched, [2:1] quarter_turns, [3] size_error
  logic             cfg_tvalid = 1'b0;
  logic             cfg_tready;
  logic [CFG_W-1:0] cfg_tdata  = '0;   // [4:0] matrix_size

  square_matrix_rotation_match dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  // Tracked block state
  logic [31:0]       first_store [DIM*DIM];
  bit                first_written [DIM*DIM];
  int                row_pos;
  int                col_pos;
  logic [3:0]        turn_flags;
  logic              count_err;
  logic [SIZE_W-1:0] size_reg;
  verdict_t          pending_verdicts [$];

  // Stimulus pattern for the first matrix
  logic [31:0] pat [DIM][DIM];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;
  int items_accepted = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("square_matrix_rotation_match verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int side_of(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > DIM) return DIM;
    return int'(s);
  endfunction

  function automatic bit reads_defined();
    int n, i, j;
    n = side_of(size_reg);
    i = row_pos;
    j = col_pos;
    return first_written[i*DIM + j] && first_written[(n-1-j)*DIM + i] &&
           first_written[(n-1-i)*DIM + n-1-j] && first_written[j*DIM + n-1-i];
  endfunction

  function automatic void track_rotation_match(logic f, logic [31:0] v, logic l);
    int       n, i, j;
    bit       at_end;
    verdict_t vd;
    n = side_of(size_reg);
    i = row_pos;
    j = col_pos;
    at_end = (i == n-1) && (j == n-1);
    if (f == FUNC_FIRST) begin
      first_store[i*DIM + j] = v;
      first_written[i*DIM + j] = 1'b1;
    end else begin
      if (first_store[i*DIM + j] != v) turn_flags[0] = 1'b0;
      if (first_store[(n-1-j)*DIM + i] != v) turn_flags[1] = 1'b0;
      if (first_store[(n-1-i)*DIM + n-1-j] != v) turn_flags[2] = 1'b0;
      if (first_store[j*DIM + n-1-i] != v) turn_flags[3] = 1'b0;
    end
    if (l) begin
      if (!at_end) count_err = 1'b1;
      if (f == FUNC_SECOND) begin
        vd.matched  = 1'b0;
        vd.turns    = TURN_0;
        vd.size_err = count_err;
        if (!count_err && turn_flags != 4'h0) begin
          vd.matched = 1'b1;
          if (turn_flags[0]) vd.turns = TURN_0;
          else if (turn_flags[1]) vd.turns = TURN_1;
          else if (turn_flags[2]) vd.turns = TURN_2;
          else vd.turns = TURN_3;
        end
        pending_verdicts = {pending_verdicts, vd};
        count_err = 1'b0;
      end
      row_pos = 0;
      col_pos = 0;
      turn_flags = 4'hF;
    end else if (at_end) begin
      count_err = 1'b1;
      row_pos = 0;
      col_pos = 0;
    end else if (j + 1 >= n) begin
      col_pos = 0;
      row_pos = i + 1;
    end else begin
      col_pos = j + 1;
    end
  endfunction

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no verdict pending", out_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[OUT_MATCHED] !== want.matched)
          report_mismatch($sformatf("matched got %b want %b",
                                    out_tdata[OUT_MATCHED], want.matched));
        if (out_tdata[OUT_QT_HI:OUT_QT_LO] !== want.turns)
          report_mismatch($sformatf("quarter_turns got %0d want %0d",
                                    out_tdata[OUT_QT_HI:OUT_QT_LO], want.turns));
        if (out_tdata[OUT_SIZE_ER] !== want.size_err)
          report_mismatch($sformatf("size_error got %b want %b",
                                    out_tdata[OUT_SIZE_ER], want.size_err));
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with in_tvalid low.
  task automatic send_item(logic f, logic [31:0] v, logic l);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    // never compare against a store entry that was not loaded yet
    if (f == FUNC_SECOND && !reads_defined()) f = FUNC_FIRST;
    in_tvalid = 1'b1;
    in_tuser  = f;
    in_tdata  = v;
    in_tlast  = l;
    do @(posedge clk); while (in_tready !== 1'b1);
    track_rotation_match(f, v, l);
    items_accepted++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] s);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_tvalid = 1'b1;
    cfg_tdata[SIZE_W-1:0] = s;
    cfg_tdata[CFG_W-1:SIZE_W] =
      (CFG_W-SIZE_W)'($urandom_range((1 << (CFG_W - SIZE_W)) - 1));
    do @(posedge clk); while (cfg_tready !== 1'b1);
    size_reg   = s;
    row_pos    = 0;
    col_pos    = 0;
    turn_flags = 4'hF;
    count_err  = 1'b0;
    @(negedge clk);
    cfg_tvalid = 1'b0;
  endtask

  // kind: 0 random, 1 tiny values, 2 constant, 3 extremes, 4 symmetric under half turn
  function automatic void fill_pattern(int n, int kind);
    logic [31:0] extreme_vals [4];
    logic [31:0] c;
    int          k;
    extreme_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    c = $urandom;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        k = i*n + j;
        case (kind)
          0: pat[i][j] = $urandom;
          1: pat[i][j] = $urandom_range(2);
          2: pat[i][j] = c;
          3: pat[i][j] = extreme_vals[$urandom_range(3)];
          default: begin
            if (k <= n*n - 1 - k) pat[i][j] = $urandom;
            else pat[i][j] = pat[n-1-i][n-1-j];
          end
        endcase
      end
    end
  endfunction

  function automatic logic [31:0] turned(int n, turn_t t, int i, int j);
    case (t)
      TURN_0:  return pat[i][j];
      TURN_1:  return pat[n-1-j][i];
      TURN_2:  return pat[n-1-i][n-1-j];
      default: return pat[j][n-1-i];
    endcase
  endfunction

  task automatic send_first(int n, int len);
    for (int k = 0; k < len; k++)
      send_item(FUNC_FIRST, pat[(k / n) % n][k % n], k == len - 1);
  endtask

  // len other than n*n gives a count error; bad_k >= 0 corrupts that element
  task automatic send_second(int n, turn_t t, int len, int bad_k);
    logic [31:0] v;
    for (int k = 0; k < len; k++) begin
      v = turned(n, t, (k / n) % n, k % n);
      if (k == bad_k) v ^= 32'h1 << $urandom_range(31);
      send_item(FUNC_SECOND, v, k == len - 1);
    end
  endtask

  task automatic send_pair(int kind, turn_t t, int bad_k);
    int n;
    n = side_of(size_reg);
    fill_pattern(n, kind);
    send_first(n, n*n);
    send_second(n, t, n*n, bad_k);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 80) return SIZE_W'($urandom_range(4, 1));
    return SIZE_W'($urandom_range(8, 5));
  endfunction

  task automatic test_reset_size();
    send_pair(0, TURN_1, -1);
  endtask

  task automatic test_each_turn();
    write_size(2);
    pat[0][0] = 32'h8000_0000;
    pat[0][1] = 32'h7FFF_FFFF;
    pat[1][0] = 32'h0000_0000;
    pat[1][1] = 32'hFFFF_FFFF;
    send_first(2, 4);
    for (int t = 0; t < 4; t++) send_second(2, turn_t'(t), 4, -1);
    send_second(2, TURN_2, 4, 3);
  endtask

  task automatic test_size_extremes();
    write_size(0);
    fill_pattern(1, 0);
    send_first(1, 1);
    send_second(1, TURN_0, 1, -1);
    write_size(31);
    send_pair(4, TURN_3, -1);
  endtask

  task automatic test_count_errors();
    write_size(3);
    fill_pattern(3, 0);
    send_first(3, 9);
    send_second(3, TURN_0, 4, -1);
    send_second(3, TURN_1, 10, -1);
    send_first(3, 5);
    send_first(3, 9);
    send_second(3, TURN_2, 9, -1);
    send_second(3, TURN_2, 9, -1);
    for (int k = 0; k < 4; k++) send_item(FUNC_SECOND, turned(3, TURN_0, k / 3, k % 3), 1'b0);
    write_size(3);
    send_second(3, TURN_0, 9, -1);
    // first- and second-matrix beats interleaved on shared positions
    for (int k = 0; k < 9; k++)
      send_item((k % 3 == 1) ? FUNC_FIRST : FUNC_SECOND,
                turned(3, TURN_0, k / 3, k % 3), k == 8);
  endtask

  task automatic test_drain_pause();
    write_size(2);
    send_pair(0, TURN_0, -1);
    wait_drained();
    send_pair(1, turn_t'($urandom_range(3)), -1);
  endtask

  task automatic run_traffic(int send_pct, int stall_pct, int goal);
    int    stop_at, sets, n, r, bad_k;
    turn_t t;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_accepted + goal;
    sets = 0;
    while (items_accepted < stop_at) begin
      if (sets % 6 == 0) write_size(pick_size());
      sets++;
      n = side_of(size_reg);
      t = turn_t'($urandom_range(3));
      bad_k = ($urandom_range(3) == 0) ? int'($urandom_range(n*n - 1)) : -1;
      r = $urandom_range(99);
      if (r < 60) begin
        send_pair($urandom_range(4), t, bad_k);
      end else if (r < 72) begin
        send_second(n, t, n*n, bad_k);
      end else if (r < 80) begin
        send_second(n, t, $urandom_range(n*n + n, 1), -1);
      end else if (r < 88) begin
        send_pair($urandom_range(4), t, bad_k);
        wait_drained();
      end else begin
        repeat ($urandom_range(8, 1))
          send_item(1'($urandom_range(1)),
                    $urandom_range(1) ? $urandom : pat[$urandom_range(n-1)][0],
                    $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    size_reg   = SIZE_W'(SIZE_RESET);
    row_pos    = 0;
    col_pos    = 0;
    turn_flags = 4'hF;
    count_err  = 1'b0;
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++) pat[i][j] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_size();
    test_each_turn();
    test_size_extremes();
    test_count_errors();
    test_drain_pause();
    run_traffic(0, 0, 75);
    run_traffic(87, 0, 75);
    run_traffic(0, 87, 75);
    run_traffic(7, 7, 75);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("square_matrix_rotation_match verification clean");
    end else begin
      $display("square_matrix_rotation_match verification failed");
    end
    $finish;
  end

endmodule
